// File: hw/rtl/vrpu_pkg.sv
// vrpu_pkg: shared types, constants and helpers for the verlet particle update
// no dependencies
package vrpu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TIME_FRAC     = 24;
    localparam int NUM_W         = 64;
    localparam int QUOT_BITS     = 42;
    localparam int CLAMP_W       = 41;
    localparam int SUM_W         = 43;
    localparam logic [CLAMP_W-1:0] MAG_CLAMP = CLAMP_W'(1) << 40;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SAT  = 2'd1;
    localparam logic [1:0] STATUS_ZERO = 2'd2;

    localparam logic REG_HALF_DT_FORCE = 1'b0;
    localparam logic REG_DT_POSITION   = 1'b1;

    localparam logic OP_FIRST_HALF = 1'b0;

    typedef struct packed {
        logic               op;
        logic               in_group;
        logic [31:0]        particle_mass;
        logic [31:0]        inertia;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] force_in;
        logic signed [31:0] spin;
        logic signed [31:0] torque_in;
        logic               last_in_batch;
    } item_t;

    typedef struct packed {
        logic signed [31:0] new_position;
        logic signed [31:0] new_velocity;
        logic signed [31:0] new_spin;
        logic [1:0]         status;
        logic               last_out;
    } result_t;

    // sideband that rides along the divider
    typedef struct packed {
        logic               op;
        logic               in_group;
        logic               zero_div;
        logic               neg_f;
        logic               neg_t;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] spin;
        logic               last;
    } side_t;

    // {flag, value}: saturate a wide signed sum to 32 bits
    function automatic logic [32:0] sat32(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'sh7fff_ffff);
        lo = -SUM_W'(33'sh0_8000_0000);
        if (s > hi)
            return {1'b1, 32'h7fff_ffff};
        else if (s < lo)
            return {1'b1, 32'h8000_0000};
        else
            return {1'b0, s[31:0]};
    endfunction

    // sign-extend 32 bits and add a signed magnitude
    function automatic logic signed [SUM_W-1:0] add_mag(input logic signed [31:0] base,
                                                          input logic neg,
                                                          input logic [CLAMP_W-1:0] mag);
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] m;
        b = SUM_W'(base);
        m = $signed({2'b00, mag});
        return neg ? b - m : b + m;
    endfunction

endpackage

// File: hw/rtl/vrpu_div.sv
// vrpu_div: pipelined restoring divider, one quotient bit per stage
// depends on vrpu_pkg
module vrpu_div
    import vrpu_pkg::*;
#(
    parameter int DW = 40
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [NUM_W-1:0]     num,
    input  logic [DW-1:0]        den,
    output logic [QUOT_BITS-1:0] quot,
    output logic                 ovf
);

    localparam int HI_W = NUM_W - QUOT_BITS;

    logic [DW-1:0]        rem_reg [QUOT_BITS];
    logic [QUOT_BITS-1:0] low_reg [QUOT_BITS];
    logic [QUOT_BITS-1:0] q_reg   [QUOT_BITS];
    logic [DW-1:0]        den_reg [QUOT_BITS];
    logic                 ovf_reg [QUOT_BITS];

    genvar k;
    generate
        for (k = 0; k < QUOT_BITS; k++)
        begin : g_step
            logic [DW-1:0]        rem_in;
            logic [QUOT_BITS-1:0] low_in;
            logic [QUOT_BITS-1:0] q_in;
            logic [DW-1:0]        den_in;
            logic                 ovf_in;
            logic [DW:0]          trial;
            logic [DW:0]          diff;
            logic                 ge;

            if (k == 0)
            begin : g_first
                // quotient of 2^42 or more is clamped anyway
                assign rem_in = DW'(num[NUM_W-1:QUOT_BITS]);
                assign low_in = num[QUOT_BITS-1:0];
                assign q_in   = '0;
                assign den_in = den;
                assign ovf_in = (DW'(num[NUM_W-1:QUOT_BITS]) >= den) && (HI_W <= DW);
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign low_in = low_reg[k-1];
                assign q_in   = q_reg[k-1];
                assign den_in = den_reg[k-1];
                assign ovf_in = ovf_reg[k-1];
            end

            assign trial = {rem_in, low_in[QUOT_BITS-1]};
            assign diff  = trial - {1'b0, den_in};
            assign ge    = trial >= {1'b0, den_in};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                    low_reg[k] <= low_in << 1;
                    q_reg[k]   <= {q_in[QUOT_BITS-2:0], ge};
                    den_reg[k] <= den_in;
                    ovf_reg[k] <= ovf_in;
                end
            end
        end
    endgenerate

    assign quot = q_reg[QUOT_BITS-1];
    assign ovf  = ovf_reg[QUOT_BITS-1];

endmodule

// File: hw/rtl/verlet_rigid_particle_update.sv
// verlet_rigid_particle_update: streaming velocity-verlet update of one particle axis
// depends on vrpu_pkg and vrpu_div
//
// one beat in, one beat out, one beat per clock sustained while result_stall
// does not hold the pipe. each beat holds one axis of one particle. op 0 does
// the first half step (velocity, spin and position), op 1 the final half step
// (velocity and spin, position kept). particles outside the group and particles
// with zero mass or inertia pass through (the latter, when in the group, flagged
// with status 2). a beat runs through stages a, b and c, the two 42-stage
// pipelined dividers for force/mass and torque/inertia, then stages d, e and f.
// the whole pipe moves on one enable: it holds while a result beat sits on the
// output and result_stall is high, so item_stall follows that condition. half_dt_force
// and dt_position are read live; write them only while the pipe is empty.
module verlet_rigid_particle_update
    import vrpu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  logic    wr_index,
    input  logic [31:0] wr_data,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int SH = TIME_FRAC - FRAC_BITS;
    localparam int DW = 32 + SH;

    // config registers
    logic [31:0] half_dt_force_reg;
    logic [31:0] dt_position_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_dt_force_reg <= '0;
            dt_position_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_HALF_DT_FORCE: half_dt_force_reg <= wr_data;
                REG_DT_POSITION:   dt_position_reg   <= wr_data;
                default:           half_dt_force_reg <= half_dt_force_reg;
            endcase
        end
    end

    // global advance: only a held output beat stops the pipe
    logic adv;
    assign adv        = !(result_valid && result_stall);
    assign item_stall = !adv;

    // stage a: input register
    logic  a_valid_reg;
    item_t a_reg;

    // stage b: magnitudes times half step
    logic        b_valid_reg;
    side_t       b_side_reg;
    logic [63:0] b_prodf_reg;
    logic [63:0] b_prodt_reg;
    logic [31:0] b_mass_reg;
    logic [31:0] b_inert_reg;

    // stage c: rounded numerators into the dividers
    logic             c_valid_reg;
    side_t            c_side_reg;
    logic [NUM_W-1:0] c_numf_reg;
    logic [NUM_W-1:0] c_numt_reg;
    logic [DW-1:0]    c_denf_reg;
    logic [DW-1:0]    c_dent_reg;

    // divider delay line for valid and sideband
    logic  dl_valid_reg [QUOT_BITS];
    side_t dl_side_reg  [QUOT_BITS];

    // stage d: new velocity and spin
    logic               d_valid_reg;
    side_t              d_side_reg;
    logic signed [31:0] d_nv_reg;
    logic signed [31:0] d_nw_reg;
    logic               d_sat_reg;

    // stage e: position increment product
    logic               e_valid_reg;
    side_t              e_side_reg;
    logic signed [31:0] e_nv_reg;
    logic signed [31:0] e_nw_reg;
    logic               e_sat_reg;
    logic [63:0]        e_prodx_reg;

    // stage f: output register
    logic    f_valid_reg;
    result_t f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            for (int i = 0; i < QUOT_BITS; i++)
                dl_valid_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg     <= item_valid;
            b_valid_reg     <= a_valid_reg;
            c_valid_reg     <= b_valid_reg;
            dl_valid_reg[0] <= c_valid_reg;
            for (int i = 1; i < QUOT_BITS; i++)
                dl_valid_reg[i] <= dl_valid_reg[i-1];
            d_valid_reg     <= dl_valid_reg[QUOT_BITS-1];
            e_valid_reg     <= d_valid_reg;
            f_valid_reg     <= e_valid_reg;
        end
    end

    // stage a -> b
    logic [31:0] magf;
    logic [31:0] magt;
    side_t       a_side;

    always_comb
    begin
        magf = a_reg.force_in[31]  ? 32'(-a_reg.force_in)  : a_reg.force_in;
        magt = a_reg.torque_in[31] ? 32'(-a_reg.torque_in) : a_reg.torque_in;
        a_side.op       = a_reg.op;
        a_side.in_group = a_reg.in_group;
        a_side.zero_div = (a_reg.particle_mass == '0) || (a_reg.inertia == '0);
        a_side.neg_f    = a_reg.force_in[31];
        a_side.neg_t    = a_reg.torque_in[31];
        a_side.position = a_reg.position;
        a_side.velocity = a_reg.velocity;
        a_side.spin     = a_reg.spin;
        a_side.last     = a_reg.last_in_batch;
    end

    // stage b -> c: add half the divisor for round to nearest
    logic [NUM_W-1:0] dfull_f;
    logic [NUM_W-1:0] dfull_t;

    always_comb
    begin
        dfull_f = NUM_W'(b_mass_reg) << SH;
        dfull_t = NUM_W'(b_inert_reg) << SH;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg       <= item;
            b_side_reg  <= a_side;
            b_prodf_reg <= 64'(magf) * 64'(half_dt_force_reg);
            b_prodt_reg <= 64'(magt) * 64'(half_dt_force_reg);
            b_mass_reg  <= a_reg.particle_mass;
            b_inert_reg <= a_reg.inertia;
            c_side_reg  <= b_side_reg;
            c_numf_reg  <= b_prodf_reg + (dfull_f >> 1);
            c_numt_reg  <= b_prodt_reg + (dfull_t >> 1);
            c_denf_reg  <= DW'(b_mass_reg) << SH;
            c_dent_reg  <= DW'(b_inert_reg) << SH;
            dl_side_reg[0] <= c_side_reg;
            for (int i = 1; i < QUOT_BITS; i++)
                dl_side_reg[i] <= dl_side_reg[i-1];
        end
    end

    logic [QUOT_BITS-1:0] qf;
    logic [QUOT_BITS-1:0] qt;
    logic                 ovf_f;
    logic                 ovf_t;

    vrpu_div #(.DW(DW)) u_div_force
    (
        .clk  (clk),
        .en   (adv),
        .num  (c_numf_reg),
        .den  (c_denf_reg),
        .quot (qf),
        .ovf  (ovf_f)
    );

    vrpu_div #(.DW(DW)) u_div_torque
    (
        .clk  (clk),
        .en   (adv),
        .num  (c_numt_reg),
        .den  (c_dent_reg),
        .quot (qt),
        .ovf  (ovf_t)
    );

    // divider out -> stage d: clamp quotient, add, saturate
    side_t        dv_side;
    logic [CLAMP_W-1:0] qfc;
    logic [CLAMP_W-1:0] qtc;
    logic [32:0]  satv;
    logic [32:0]  satw;

    always_comb
    begin
        dv_side = dl_side_reg[QUOT_BITS-1];
        qfc  = (ovf_f || qf > QUOT_BITS'(MAG_CLAMP)) ? MAG_CLAMP : qf[CLAMP_W-1:0];
        qtc  = (ovf_t || qt > QUOT_BITS'(MAG_CLAMP)) ? MAG_CLAMP : qt[CLAMP_W-1:0];
        satv = sat32(add_mag(dv_side.velocity, dv_side.neg_f, qfc));
        satw = sat32(add_mag(dv_side.spin, dv_side.neg_t, qtc));
    end

    // stage e magnitude of new velocity
    logic [31:0] magv;
    assign magv = d_nv_reg[31] ? 32'(-d_nv_reg) : d_nv_reg;

    // stage f: position increment and final select
    logic [63:0]        qx_full;
    logic [32:0]        satx;
    result_t            f_next;

    always_comb
    begin
        qx_full = (e_prodx_reg + (64'd1 << (TIME_FRAC - 1))) >> TIME_FRAC;
        satx    = sat32(add_mag(e_side_reg.position, e_nv_reg[31], qx_full[CLAMP_W-1:0]));
        f_next.new_position = e_side_reg.position;
        f_next.new_velocity = e_side_reg.velocity;
        f_next.new_spin     = e_side_reg.spin;
        f_next.status       = STATUS_OK;
        f_next.last_out     = e_side_reg.last;
        if (e_side_reg.in_group)
        begin
            if (e_side_reg.zero_div)
                f_next.status = STATUS_ZERO;
            else
            begin
                f_next.new_velocity = e_nv_reg;
                f_next.new_spin     = e_nw_reg;
                if (e_side_reg.op == OP_FIRST_HALF)
                    f_next.new_position = satx[31:0];
                if (e_sat_reg || (e_side_reg.op == OP_FIRST_HALF && satx[32]))
                    f_next.status = STATUS_SAT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_side_reg  <= dv_side;
            d_nv_reg    <= satv[31:0];
            d_nw_reg    <= satw[31:0];
            d_sat_reg   <= satv[32] || satw[32];
            e_side_reg  <= d_side_reg;
            e_nv_reg    <= d_nv_reg;
            e_nw_reg    <= d_nw_reg;
            e_sat_reg   <= d_sat_reg;
            e_prodx_reg <= 64'(magv) * 64'(dt_position_reg);
            f_reg       <= f_next;
        end
    end

    assign result_valid = f_valid_reg;
    assign result       = f_reg;

    // an accepted beat lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> a_valid_reg)
        else $error("accepted beat lost at input stage");

    // a saturated result carries a rail value somewhere
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == STATUS_SAT |->
            result.new_velocity == 32'sh7fff_ffff || result.new_velocity == 32'sh8000_0000 ||
            result.new_spin == 32'sh7fff_ffff || result.new_spin == 32'sh8000_0000 ||
            result.new_position == 32'sh7fff_ffff || result.new_position == 32'sh8000_0000)
        else $error("saturation flagged without rail value");

    // a beat in the last delay stage reaches stage d when the pipe moves
    assert property (@(posedge clk) disable iff (!rst_n)
        dl_valid_reg[QUOT_BITS-1] && adv |=> d_valid_reg)
        else $error("beat dropped behind divider");

endmodule

// File: sim/testbench.sv
// testbench: self-checking regression for verlet_rigid_particle_update
// depends on vrpu_pkg and the verlet_rigid_particle_update rtl
`timescale 1ns / 1ps

module testbench;
    import vrpu_pkg::*;

    localparam int LATENCY = QUOT_BITS + 6;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic        wr_index;
    logic [31:0] wr_data;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;

    verlet_rigid_particle_update uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // predictor copy of the two time-factor registers
    logic [31:0] kick_factor;
    logic [31:0] drift_factor;

    result_t expected_updates[$];
    int      mismatches;
    int      beats_sent;
    int      beats_checked;
    int      sat_seen;
    int      zero_seen;
    int      idle_cycles;
    bit      stall_enable;

    always #6 clk = ~clk;

    // sign(val) * round_half_away(|val| * factor / divisor), magnitude clamped at 2^40
    function automatic longint scaled_step(input longint val, input logic [31:0] factor,
                                           input logic [63:0] divisor);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] q;
        neg = val < 0;
        mag = neg ? 64'(-val) : 64'(val);
        q = (mag * 64'(factor) + divisor / 2) / divisor;
        if (q > (64'd1 << 40))
            q = 64'd1 << 40;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp32(input longint s, inout logic flag);
        if (s > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (s < -64'sd2147483648)
        begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return s;
    endfunction

    function automatic result_t predict_update(input item_t it);
        result_t     r;
        logic        sat;
        longint      nx;
        longint      nv;
        longint      nw;
        logic [63:0] dshift;
        sat = 1'b0;
        nx = longint'(it.position);
        nv = longint'(it.velocity);
        nw = longint'(it.spin);
        r.status = STATUS_OK;
        dshift = 64'd1 << (TIME_FRAC - FRAC_BITS_DEF);
        if (it.in_group)
        begin
            if (it.particle_mass == 0 || it.inertia == 0)
                r.status = STATUS_ZERO;
            else
            begin
                nv = clamp32(nv + scaled_step(longint'(it.force_in), kick_factor,
                             64'(it.particle_mass) * dshift), sat);
                nw = clamp32(nw + scaled_step(longint'(it.torque_in), kick_factor,
                             64'(it.inertia) * dshift), sat);
                if (it.op == OP_FIRST_HALF)
                    nx = clamp32(nx + scaled_step(nv, drift_factor, 64'd1 << TIME_FRAC), sat);
                r.status = sat ? STATUS_SAT : STATUS_OK;
            end
        end
        r.new_position = nx[31:0];
        r.new_velocity = nv[31:0];
        r.new_spin = nw[31:0];
        r.last_out = it.last_in_batch;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch at beat %0d: %s got %h expected %h", beats_checked, what, got, want);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // result side: sample at the edge, compare against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_updates.size() == 0)
            begin
                mismatches++;
                $display("unexpected result beat");
            end
            else
            begin
                result_t want;
                want = expected_updates.pop_front();
                if (result.new_position !== want.new_position)
                    report_mismatch("new_position", result.new_position, want.new_position);
                if (result.new_velocity !== want.new_velocity)
                    report_mismatch("new_velocity", result.new_velocity, want.new_velocity);
                if (result.new_spin !== want.new_spin)
                    report_mismatch("new_spin", result.new_spin, want.new_spin);
                if (result.status !== want.status)
                    report_mismatch("status", 32'(result.status), 32'(want.status));
                if (result.last_out !== want.last_out)
                    report_mismatch("last_out", 32'(result.last_out), 32'(want.last_out));
                if (want.status == STATUS_SAT)
                    sat_seen++;
                if (want.status == STATUS_ZERO)
                    zero_seen++;
            end
            beats_checked++;
        end
    end

    // receiver stall pattern, held at a fixed length per stretch
    initial
    begin
        int n;
        result_stall = 1'b0;
        forever
        begin
            n = gap_length();
            @(posedge clk);
            if (stall_enable && n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            n = $urandom_range(1, 12);
            repeat (n - 1) @(posedge clk);
        end
    end

    // watchdog on cycles with no accepted beat on either side and no register write
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("verlet_rigid_particle_update regression: fail");
            $finish;
        end
    end

    // one beat on the item channel, optional gap first
    task automatic send_item(input item_t it, input bit allow_gap);
        int n;
        n = allow_gap ? gap_length() : 0;
        if (n > 0)
        begin
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        expected_updates.push_back(predict_update(it));
        beats_sent++;
    endtask

    task automatic end_burst();
        item_valid <= 1'b0;
    endtask

    task automatic drain_pipe();
        end_burst();
        @(posedge clk);
        while (expected_updates.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // write strobe for one cycle, then the predictor copy is updated
    task automatic write_reg(input logic index, input logic [31:0] value);
        wr_en <= 1'b1;
        wr_index <= index;
        wr_data <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        if (index == REG_HALF_DT_FORCE)
            kick_factor = value;
        else
            drift_factor = value;
    endtask

    function automatic item_t blank_item();
        item_t it;
        it = '0;
        it.in_group = 1'b1;
        it.particle_mass = 32'h0001_0000;
        it.inertia = 32'h0001_0000;
        return it;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 255);
            3: return -$urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.op = 1'($urandom_range(0, 1));
        it.in_group = $urandom_range(0, 7) != 0;
        it.particle_mass = ($urandom_range(0, 15) == 0) ? 32'd0 :
                           ($urandom_range(0, 1) ? $urandom : $urandom_range(1, 32'h0010_0000));
        it.inertia = ($urandom_range(0, 15) == 0) ? 32'd0 :
                     ($urandom_range(0, 1) ? $urandom : $urandom_range(1, 32'h0010_0000));
        it.position = random_word();
        it.velocity = random_word();
        it.force_in = random_word();
        it.spin = random_word();
        it.torque_in = random_word();
        it.last_in_batch = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // default registers after reset are zero: everything passes through
    task automatic test_reset_values();
        item_t it;
        it = blank_item();
        it.velocity = 32'h0002_0000;
        it.force_in = 32'h0100_0000;
        send_item(it, 1'b0);
        drain_pipe();
    endtask

    // field extremes, both ops, group and zero-divisor cases
    task automatic test_directed();
        item_t it;
        write_reg(REG_HALF_DT_FORCE, 32'h0080_0000);
        write_reg(REG_DT_POSITION, 32'h0100_0000);
        for (int op = 0; op < 2; op++)
        begin
            it = blank_item();
            it.op = op[0];
            it.position = 32'h0003_0000;
            it.velocity = 32'h0001_8000;
            it.force_in = 32'h0002_0000;
            it.spin = 32'hffff_0000;
            it.torque_in = 32'hfffe_0000;
            it.last_in_batch = op[0];
            send_item(it, 1'b0);
            it.in_group = 1'b0;
            send_item(it, 1'b0);
            it = blank_item();
            it.op = op[0];
            it.particle_mass = 32'd0;
            it.force_in = 32'h7fff_ffff;
            send_item(it, 1'b0);
            it = blank_item();
            it.op = op[0];
            it.inertia = 32'd0;
            send_item(it, 1'b0);
            // saturation both ways with the smallest mass
            it = blank_item();
            it.op = op[0];
            it.particle_mass = 32'd1;
            it.inertia = 32'hffff_ffff;
            it.velocity = 32'h7fff_ffff;
            it.force_in = 32'h7fff_ffff;
            it.position = 32'h7fff_ffff;
            it.spin = 32'h8000_0000;
            it.torque_in = 32'h8000_0000;
            send_item(it, 1'b0);
            it.velocity = 32'h8000_0000;
            it.force_in = 32'h8000_0000;
            it.position = 32'h8000_0000;
            send_item(it, 1'b0);
            // unit force against unit velocity of opposite sign, with a mass of 2
            it = blank_item();
            it.op = op[0];
            it.particle_mass = 32'd2;
            it.force_in = 32'hffff_ffff;
            it.velocity = 32'd1;
            send_item(it, 1'b0);
            it.force_in = 32'd1;
            it.velocity = 32'hffff_ffff;
            send_item(it, 1'b0);
        end
        drain_pipe();
    endtask

    // several register settings, extremes included, random items in each
    task automatic test_random_settings();
        logic [31:0] kick_values[5];
        logic [31:0] drift_values[5];
        kick_values = '{32'hffff_ffff, 32'd0, 32'h0000_4000, 32'h0100_0000, 32'h0};
        drift_values = '{32'hffff_ffff, 32'h0010_0000, 32'd0, 32'd1, 32'h0};
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_HALF_DT_FORCE, phase == 4 ? $urandom : kick_values[phase]);
            write_reg(REG_DT_POSITION, phase == 4 ? $urandom : drift_values[phase]);
            stall_enable = phase != 2;
            for (int i = 0; i < 250; i++)
            begin
                send_item(random_item(), phase != 3);
                // sender holds off until the pipe is empty
                if (i == 120)
                begin
                    end_burst();
                    @(posedge clk);
                    while (expected_updates.size() != 0)
                        @(posedge clk);
                end
            end
            stall_enable = 1'b1;
            drain_pipe();
        end
    endtask

    initial
    begin
        int limit;
        clk = 1'b0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_HALF_DT_FORCE;
        wr_data = '0;
        item_valid = 1'b0;
        item = '0;
        kick_factor = '0;
        drift_factor = '0;
        mismatches = 0;
        beats_sent = 0;
        beats_checked = 0;
        sat_seen = 0;
        zero_seen = 0;
        idle_cycles = 0;
        stall_enable = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed();
        test_random_settings();

        limit = 0;
        while (expected_updates.size() != 0 && limit < 10 * LATENCY)
        begin
            @(posedge clk);
            limit++;
        end
        if (expected_updates.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", expected_updates.size());
        end

        $display("covered %0d beats in, %0d beats out, %0d saturated, %0d zero divisor",
                 beats_sent, beats_checked, sat_seen, zero_seen);
        $display("both half steps, group pass-through and a range of time factors exercised");
        if (mismatches == 0)
            $display("verlet_rigid_particle_update regression: pass");
        else
            $display("verlet_rigid_particle_update regression: fail");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/vrpu_pkg.sv
hw/rtl/vrpu_div.sv
hw/rtl/verlet_rigid_particle_update.sv
sim/testbench.sv
